// File: rtl/aepq_pkg.sv
// ----------------------------------------------------------------------------
// aepq_pkg
// Shared types, codes and defaults for the active/expired priority queues.
// ----------------------------------------------------------------------------
package aepq_pkg;

	// default sizes, handed to the top level parameters
	localparam int NUM_LEVELS_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_WIDTH_DEF    = 8;

	// fixed field widths
	localparam int CMD_W    = 1;
	localparam int TASK_W   = 8;
	localparam int PRIO_W   = 4;
	localparam int STATUS_W = 2;
	localparam int LEVEL_W  = 3;
	localparam int EXP_W    = 9;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_NEXT = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_PRIO = 2'd3;

	// dynamic priority marking a used-up quantum
	localparam logic signed [PRIO_W-1:0] DYN_EXPIRED = -4'sd1;

	// expired count saturates here
	localparam logic [EXP_W-1:0] EXP_MAX = 9'd511;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the incoming command
		logic exec;      // run the queue operation
		logic load_out;  // move the result into the output register
	} aepq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic retry;     // banks swapped, pop must be run again
		logic out_free;  // output register can take a result
	} aepq_sts_t;

endpackage

// File: rtl/aepq_ctrl.sv
// ----------------------------------------------------------------------------
// aepq_ctrl
// Command sequencer: accept, execute (repeated once after a bank swap),
// hand the result to the output register.
// ----------------------------------------------------------------------------
module aepq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  aepq_pkg::aepq_sts_t sts,
	output aepq_pkg::aepq_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (!sts.retry) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready     = ready_q;
	assign cmd.capture  = in_valid && ready_q;
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.load_out = (state_q == S_RESP) && sts.out_free;

endmodule

// File: rtl/aepq_dpath.sv
// ----------------------------------------------------------------------------
// aepq_dpath
// Queue pointers, task store, level search and output register.
// ----------------------------------------------------------------------------
module aepq_dpath #(
	parameter int NUM_LEVELS  = aepq_pkg::NUM_LEVELS_DEF,
	parameter int QUEUE_DEPTH = aepq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = aepq_pkg::ID_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  aepq_pkg::aepq_cmd_t                   cmd,
	output aepq_pkg::aepq_sts_t                   sts,
	input  logic [aepq_pkg::CMD_W-1:0]            in_cmd,
	input  logic [aepq_pkg::TASK_W-1:0]           in_task_id,
	input  logic signed [aepq_pkg::PRIO_W-1:0]    in_dyn_prio,
	input  logic [aepq_pkg::PRIO_W-1:0]           in_static_prio,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [aepq_pkg::STATUS_W-1:0]         out_status,
	output logic [aepq_pkg::TASK_W-1:0]           out_id,
	output logic [aepq_pkg::LEVEL_W-1:0]          out_prio
);

	localparam int LvlW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int QW    = LvlW + 1;
	// queue index is {bank, level}, so each bank spans a power of two
	localparam int NQ    = 2 * (2 ** LvlW);
	localparam int HeadW = $clog2(QUEUE_DEPTH);
	localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SumW  = HeadW + 1;
	localparam int AddrW = QW + HeadW;

	// latched command
	logic [aepq_pkg::CMD_W-1:0]         cmd_q;
	logic [ID_WIDTH-1:0]                id_q;
	logic signed [aepq_pkg::PRIO_W-1:0] dyn_q;
	logic [aepq_pkg::PRIO_W-1:0]        stat_q;

	// queue state
	logic [HeadW-1:0]              head_q  [NQ];
	logic [CntW-1:0]               count_q [NQ];
	logic                          bank_q;
	logic [aepq_pkg::EXP_W-1:0]    exp_q;
	logic [ID_WIDTH-1:0]           store_mem [2**AddrW];
	logic [ID_WIDTH-1:0]           rd_data_q;

	// result staging and output register
	logic [aepq_pkg::STATUS_W-1:0] res_status_q;
	logic [aepq_pkg::LEVEL_W-1:0]  res_prio_q;
	logic                          res_got_q;
	logic                          out_valid_q;
	logic [aepq_pkg::STATUS_W-1:0] out_status_q;
	logic [aepq_pkg::TASK_W-1:0]   out_id_q;
	logic [aepq_pkg::LEVEL_W-1:0]  out_prio_q;

	// combinational
	logic             found;
	logic [LvlW-1:0]  pop_lvl;
	logic             is_exp;
	logic             range_ok;
	logic [LvlW-1:0]  add_lvl;
	logic             add_bank;
	logic             is_next;
	logic [QW-1:0]    q_sel;
	logic [HeadW-1:0] h;
	logic [CntW-1:0]  c;
	logic             full;
	logic [SumW-1:0]  sum;
	logic [HeadW-1:0] tail;
	logic [HeadW-1:0] head_nx;
	logic             do_pop;
	logic             do_push;
	logic             do_swap;

	// highest non-empty level of the active bank
	always_comb begin
		found   = 1'b0;
		pop_lvl = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (count_q[{bank_q, LvlW'(l)}] != '0) begin
				found   = 1'b1;
				pop_lvl = LvlW'(l);
			end
		end
	end

	always_comb begin
		is_next  = (cmd_q == aepq_pkg::CMD_NEXT);
		is_exp   = (dyn_q == aepq_pkg::DYN_EXPIRED);
		range_ok = is_exp ? ((stat_q != '0) && (int'(stat_q) <= NUM_LEVELS))
		                  : (!dyn_q[3] && (int'(dyn_q[2:0]) < NUM_LEVELS));
		add_lvl  = is_exp ? LvlW'(stat_q - 4'd1) : LvlW'(dyn_q[2:0]);
		add_bank = bank_q ^ is_exp;
		q_sel    = is_next ? {bank_q, pop_lvl} : {add_bank, add_lvl};
		h        = head_q[q_sel];
		c        = count_q[q_sel];
		full     = (c == CntW'(QUEUE_DEPTH));
		sum      = SumW'(h) + SumW'(c);
		tail     = (sum >= SumW'(QUEUE_DEPTH)) ? HeadW'(sum - SumW'(QUEUE_DEPTH))
		                                      : HeadW'(sum);
		head_nx  = (h == HeadW'(QUEUE_DEPTH - 1)) ? '0 : h + HeadW'(1);
		do_pop   = cmd.exec && is_next && found;
		do_swap  = cmd.exec && is_next && !found && (exp_q != '0);
		do_push  = cmd.exec && !is_next && range_ok && !full;
	end

	assign sts.retry    = do_swap;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= in_cmd;
			id_q   <= ID_WIDTH'(in_task_id);
			dyn_q  <= in_dyn_prio;
			stat_q <= in_static_prio;
		end
	end

	// task store, one access per command
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_mem[{q_sel, tail}] <= id_q;
		end
		if (do_pop) begin
			rd_data_q <= store_mem[{q_sel, h}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NQ; q++) begin
				head_q[q]  <= '0;
				count_q[q] <= '0;
			end
			bank_q <= 1'b0;
			exp_q  <= '0;
		end else begin
			if (do_pop) begin
				head_q[q_sel]  <= head_nx;
				count_q[q_sel] <= c - CntW'(1);
			end
			if (do_push) begin
				count_q[q_sel] <= c + CntW'(1);
				if (is_exp && (exp_q != aepq_pkg::EXP_MAX)) begin
					exp_q <= exp_q + 1'b1;
				end
			end
			if (do_swap) begin
				bank_q <= ~bank_q;
				exp_q  <= '0;
			end
		end
	end

	// result of the command
	always_ff @(posedge clk) begin
		if (cmd.exec && !do_swap) begin
			res_got_q <= do_pop;
			if (is_next) begin
				res_status_q <= found ? aepq_pkg::ST_OK : aepq_pkg::ST_NONE;
				res_prio_q   <= found ? aepq_pkg::LEVEL_W'(pop_lvl) : '0;
			end else if (!range_ok) begin
				res_status_q <= aepq_pkg::ST_BAD_PRIO;
				res_prio_q   <= '0;
			end else begin
				res_status_q <= full ? aepq_pkg::ST_FULL : aepq_pkg::ST_OK;
				res_prio_q   <= aepq_pkg::LEVEL_W'(add_lvl);
			end
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_prio_q   <= res_prio_q;
			out_id_q     <= res_got_q ? aepq_pkg::TASK_W'(rd_data_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_prio   = out_prio_q;

endmodule

// File: rtl/active_expired_priority_queues.sv
// ----------------------------------------------------------------------------
// active_expired_priority_queues
// Active/expired banks of per-level task id FIFOs with a take-highest command.
// ----------------------------------------------------------------------------
// Flow: a command is captured on input transfer, executed, then loaded into
//   the output register; a take that swaps the banks executes again.
// Commands run one at a time, with a single task store access each; loading
//   waits while the output register holds a result not yet taken.
// Reset: heads, counts, active bank and expired count clear at once; the
//   task store is not cleared (only written slots are ever read).
// ----------------------------------------------------------------------------
module active_expired_priority_queues #(
	parameter int NUM_LEVELS  = aepq_pkg::NUM_LEVELS_DEF,   // 1..8
	parameter int QUEUE_DEPTH = aepq_pkg::QUEUE_DEPTH_DEF,  // 2..256
	parameter int ID_WIDTH    = aepq_pkg::ID_WIDTH_DEF      // 1..8, id bits kept
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [aepq_pkg::S_DATA_W-1:0]     s_tdata,  // task_id[7:0], dyn_prio[11:8],
	                                                    // static_prio[15:12]
	input  logic [aepq_pkg::CMD_W-1:0]        s_tuser,  // cmd[0]
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [aepq_pkg::M_DATA_W-1:0]     m_tdata,  // out_id[7:0], assigned_prio[10:8],
	                                                    // zero [15:11]
	output logic [aepq_pkg::STATUS_W-1:0]     m_tuser   // status[1:0]
);

	aepq_pkg::aepq_cmd_t          cmd;
	aepq_pkg::aepq_sts_t          sts;
	logic [aepq_pkg::TASK_W-1:0]  out_id;
	logic [aepq_pkg::LEVEL_W-1:0] out_prio;

	// sequencer: one command at a time, the output register lets the
	// next command in while a result still waits downstream
	aepq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// queues, level search and output register
	aepq_dpath #(
		.NUM_LEVELS  (NUM_LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_cmd         (s_tuser),
		.in_task_id     (s_tdata[7:0]),
		.in_dyn_prio    (s_tdata[11:8]),
		.in_static_prio (s_tdata[15:12]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_status     (m_tuser),
		.out_id         (out_id),
		.out_prio       (out_prio)
	);

	assign m_tdata = {5'b0, out_prio, out_id};

endmodule

// File: bench/active_expired_priority_queues_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// active_expired_priority_queues_tb
// Self-checking bench for the active/expired task queues. Add and take
// commands stream in through a backlog and a clocked driver. A model of the
// two banks predicts every reply on acceptance, and a clocked monitor checks
// each reply, field by field, against the oldest prediction. Both sides
// stall at random, and the result side holds off for one long stretch.
// ----------------------------------------------------------------------------
module active_expired_priority_queues_tb;

	localparam int LEVELS     = aepq_pkg::NUM_LEVELS_DEF;
	localparam int DEPTH      = aepq_pkg::QUEUE_DEPTH_DEF;
	localparam int TW         = aepq_pkg::TASK_W;
	localparam int PW         = aepq_pkg::PRIO_W;
	localparam int LW         = aepq_pkg::LEVEL_W;
	localparam int RAND_CMDS  = 1300;
	localparam int TAIL_CMDS  = 150;   // no idling on either side for the last stretch
	localparam int HOLD_AFTER = 400;   // commands sent before the long result hold-off
	localparam int HOLD_LEN   = 300;
	localparam int SETTLE     = 12;    // margin after the last reply
	localparam int PAD_W      = aepq_pkg::M_DATA_W - TW - LW;

	typedef struct {
		logic [aepq_pkg::CMD_W-1:0] cmd;
		logic [TW-1:0]              task_id;
		logic signed [PW-1:0]       dyn_prio;
		logic [PW-1:0]              static_prio;
	} sched_cmd_t;

	typedef struct {
		logic [aepq_pkg::STATUS_W-1:0] status;
		logic [TW-1:0]                 out_id;
		logic [LW-1:0]                 level;
	} sched_reply_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [aepq_pkg::S_DATA_W-1:0] s_tdata;   // task_id[7:0], dyn_prio[11:8],
	                                          // static_prio[15:12]
	logic [aepq_pkg::CMD_W-1:0]    s_tuser;   // cmd[0]
	logic                          m_tvalid;
	logic                          m_tready;
	logic [aepq_pkg::M_DATA_W-1:0] m_tdata;   // out_id[7:0], assigned_prio[10:8],
	                                          // zero[15:11]
	logic [aepq_pkg::STATUS_W-1:0] m_tuser;   // status[1:0]

	// commands still to be sent, and replies predicted but not yet seen
	sched_cmd_t   cmd_backlog[$];
	sched_reply_t reply_forecast[$];

	// model of the two banks: slot store, read pointers and occupancy
	logic [TW-1:0] slot_mem [2][LEVELS][DEPTH];
	int            head_ptr [2][LEVELS];
	int            fill     [2][LEVELS];
	bit            live_bank;
	int            expired_cnt;

	int  total_cmds;
	int  cmds_sent;
	int  replies_seen;
	int  mismatches;
	int  tx_gap;
	int  rx_gap;
	logic hold_off = 1'b0;
	int  n_taken, n_empty, n_full, n_badprio, n_swaps, n_expired_adds;

	always #2 clk = ~clk;

	active_expired_priority_queues #(
		.NUM_LEVELS  (LEVELS),
		.QUEUE_DEPTH (DEPTH),
		.ID_WIDTH    (aepq_pkg::ID_WIDTH_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// ---------------------------------------------------------------- model

	function automatic bit push_id(input bit bank, input int lvl, input logic [TW-1:0] id);
		if (fill[bank][lvl] >= DEPTH)
			return 1'b0;
		slot_mem[bank][lvl][(head_ptr[bank][lvl] + fill[bank][lvl]) % DEPTH] = id;
		fill[bank][lvl]++;
		return 1'b1;
	endfunction

	// oldest task of the highest non-empty level in the live bank
	function automatic bit take_highest(output logic [TW-1:0] id, output int lvl);
		id  = '0;
		lvl = 0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (fill[live_bank][l] != 0) begin
				id  = slot_mem[live_bank][l][head_ptr[live_bank][l]];
				head_ptr[live_bank][l] = (head_ptr[live_bank][l] + 1) % DEPTH;
				fill[live_bank][l]--;
				lvl = l;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic sched_reply_t schedule_cmd(input sched_cmd_t c);
		sched_reply_t  r;
		int            dyn;
		int            lvl;
		bit            got;
		logic [TW-1:0] id;
		r.status = aepq_pkg::ST_OK;
		r.out_id = '0;
		r.level  = '0;
		dyn = c.dyn_prio;   // sign-extended
		if (c.cmd == aepq_pkg::CMD_ADD) begin
			if (c.dyn_prio == aepq_pkg::DYN_EXPIRED) begin
				// used-up quantum: requeue in the expired bank at static level
				if (c.static_prio < 1 || c.static_prio > LEVELS) begin
					r.status = aepq_pkg::ST_BAD_PRIO;
				end else begin
					lvl = int'(c.static_prio) - 1;
					r.level = lvl[LW-1:0];
					if (push_id(~live_bank, lvl, c.task_id)) begin
						if (expired_cnt < aepq_pkg::EXP_MAX)
							expired_cnt++;
						n_expired_adds++;
					end else begin
						r.status = aepq_pkg::ST_FULL;
					end
				end
			end else if (dyn < 0 || dyn >= LEVELS) begin
				r.status = aepq_pkg::ST_BAD_PRIO;
			end else begin
				r.level = dyn[LW-1:0];
				if (!push_id(live_bank, dyn, c.task_id))
					r.status = aepq_pkg::ST_FULL;
			end
		end else begin
			got = take_highest(id, lvl);
			// live bank dry but expired tasks waiting: swap and try once more
			if (!got && expired_cnt > 0) begin
				live_bank   = ~live_bank;
				expired_cnt = 0;
				n_swaps++;
				got = take_highest(id, lvl);
			end
			if (got) begin
				r.out_id = id;
				r.level  = lvl[LW-1:0];
				n_taken++;
			end else begin
				r.status = aepq_pkg::ST_NONE;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------ stimulus

	function automatic void add_cmd(input logic [TW-1:0] id,
			input logic signed [PW-1:0] dyn, input logic [PW-1:0] stat);
		sched_cmd_t c;
		c.cmd         = aepq_pkg::CMD_ADD;
		c.task_id     = id;
		c.dyn_prio    = dyn;
		c.static_prio = stat;
		cmd_backlog   = {cmd_backlog, c};
	endfunction

	// take command; the unused fields carry random junk
	function automatic void next_cmd();
		sched_cmd_t c;
		c.cmd         = aepq_pkg::CMD_NEXT;
		c.task_id     = TW'($urandom);
		c.dyn_prio    = PW'($urandom);
		c.static_prio = PW'($urandom);
		cmd_backlog   = {cmd_backlog, c};
	endfunction

	initial begin
		int  lvl;
		int  n;
		int  k;
		bit  to_expired;

		arst_n       = 1'b0;
		live_bank    = 1'b0;
		expired_cnt  = 0;
		cmds_sent    = 0;
		replies_seen = 0;
		mismatches   = 0;
		tx_gap       = 0;
		rx_gap       = 0;
		n_taken = 0; n_empty = 0; n_full = 0; n_badprio = 0; n_swaps = 0;
		n_expired_adds = 0;

		// directed opening
		next_cmd();                                   // nothing queued, no swap
		add_cmd(8'h00, 4'sd0, 4'd1);                  // lowest level, lowest id
		add_cmd(8'hFF, 4'sd7, 4'd15);                 // top level; static ignored here
		add_cmd(8'hA5, aepq_pkg::DYN_EXPIRED, 4'd1);  // expired, bottom level
		add_cmd(8'h5A, aepq_pkg::DYN_EXPIRED, 4'd8);  // expired, top level
		add_cmd(8'h11, 4'hE, 4'd3);                   // dyn -2: out of range
		add_cmd(8'h22, 4'h8, 4'd3);                   // dyn -8: out of range
		add_cmd(8'h33, aepq_pkg::DYN_EXPIRED, 4'd0);  // static zero: out of range
		add_cmd(8'h44, aepq_pkg::DYN_EXPIRED, 4'd9);  // static above levels
		add_cmd(8'h55, aepq_pkg::DYN_EXPIRED, 4'd15);
		next_cmd();                                   // FF from level 7
		next_cmd();                                   // 00 from level 0
		next_cmd();                                   // active dry: swap, 5A from level 7
		next_cmd();                                   // A5 from level 0
		next_cmd();                                   // nothing, expired count is zero
		add_cmd(8'h66, aepq_pkg::DYN_EXPIRED, 4'd4);
		next_cmd();                                   // swap again, 66 from level 3
		next_cmd();

		// random part, built from scenarios
		while (cmd_backlog.size() < RAND_CMDS) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					// flood one level up to or past its depth, then drain
					lvl        = $urandom_range(0, LEVELS - 1);
					n          = $urandom_range(DEPTH - 2, DEPTH + 4);
					to_expired = $urandom_range(0, 1);
					repeat (n) begin
						if (to_expired)
							add_cmd(TW'($urandom), aepq_pkg::DYN_EXPIRED, PW'(lvl + 1));
						else
							add_cmd(TW'($urandom), PW'(lvl), PW'($urandom));
					end
					repeat ($urandom_range(n, n + 4)) next_cmd();
				end
				2: begin
					repeat ($urandom_range(5, 30)) next_cmd();
				end
				default: begin
					repeat (20) begin
						if ($urandom_range(0, 1)) begin
							next_cmd();
						end else begin
							k = $urandom_range(0, 19);
							if (k < 13)
								add_cmd(TW'($urandom), PW'($urandom_range(0, LEVELS - 1)),
									PW'($urandom));
							else if (k < 17)
								add_cmd(TW'($urandom), aepq_pkg::DYN_EXPIRED,
									PW'($urandom_range(1, LEVELS)));
							else if (k < 19)
								add_cmd(TW'($urandom), aepq_pkg::DYN_EXPIRED, PW'($urandom));
							else
								add_cmd(TW'($urandom), PW'($urandom), PW'($urandom));
						end
					end
				end
			endcase
		end
		total_cmds = cmd_backlog.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// everything sent and every predicted reply seen
		while (cmds_sent != total_cmds || reply_forecast.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Ran %0d commands: %0d tasks taken, %0d empty takes, %0d bank swaps",
			total_cmds, n_taken, n_empty, n_swaps);
		$display("Adds: %0d into expired bank, %0d dropped on full queue, %0d bad priority",
			n_expired_adds, n_full, n_badprio);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// long result-side hold-off so the block backs up and stalls its input
	initial begin
		while (cmds_sent < HOLD_AFTER)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		hold_off <= 1'b0;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Timed out with %0d of %0d commands sent, %0d replies outstanding",
			cmds_sent, total_cmds, reply_forecast.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// -------------------------------------------------------------- driver
	// A transfer predicts its reply at once; an offered command is held
	// until it is taken; gaps come in bursts, none in the tail.
	always @(posedge clk or negedge arst_n) begin
		sched_cmd_t c;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				c = cmd_backlog[0];
				cmd_backlog.delete(0);
				reply_forecast = {reply_forecast, schedule_cmd(c)};
				cmds_sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (cmd_backlog.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (cmd_backlog.size() > TAIL_CMDS && $urandom_range(0, 11) == 0) begin
					tx_gap   = $urandom_range(0, 18);   // idle now and for a random gap after
					s_tvalid <= 1'b0;
				end else begin
					c = cmd_backlog[0];
					s_tvalid <= 1'b1;
					s_tdata  <= {c.static_prio, c.dyn_prio, c.task_id};
					s_tuser  <= c.cmd;
				end
			end
		end
	end

	// ------------------------------------------------------------- monitor
	// Checks each reply transfer against the oldest prediction and drives
	// the result-side ready with its own stall bursts.
	always @(posedge clk or negedge arst_n) begin
		sched_reply_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reply_forecast.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected reply: status %0d id %0h data %0h",
							m_tuser, m_tdata[TW-1:0], m_tdata);
				end else begin
					e = reply_forecast[0];
					reply_forecast.delete(0);
					if (m_tuser !== e.status || m_tdata[TW-1:0] !== e.out_id ||
							m_tdata[TW +: LW] !== e.level ||
							m_tdata[aepq_pkg::M_DATA_W-1 -: PAD_W] !== '0) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"Reply %0d: expected status %0d id %0h level %0d, ",
								"got status %0d id %0h level %0d pad %0h"},
								replies_seen, e.status, e.out_id, e.level, m_tuser,
								m_tdata[TW-1:0], m_tdata[TW +: LW],
								m_tdata[aepq_pkg::M_DATA_W-1 -: PAD_W]);
					end
					case (e.status)
						aepq_pkg::ST_NONE:     n_empty++;
						aepq_pkg::ST_FULL:     n_full++;
						aepq_pkg::ST_BAD_PRIO: n_badprio++;
						default:               ;
					endcase
				end
				replies_seen++;
			end
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else if (replies_seen < total_cmds - TAIL_CMDS && $urandom_range(0, 9) == 0) begin
				rx_gap   = $urandom_range(0, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

endmodule
